>>> src/scara_inverse_kinematics_assert.svh
// assertion macros for the arm solver
// no dependencies; included by the top level only
`ifndef SCARA_INVERSE_KINEMATICS_ASSERT_SVH
`define SCARA_INVERSE_KINEMATICS_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SIK_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sik assertion failed");

// next-cycle implication, checked outside reset
`define SIK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sik assertion failed");

`endif

>>> src/sik_pkg.sv
// shared widths, codes, item structs and helper functions of the arm solver
// no dependencies
package sik_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ATAN_LEN   = 24;
    localparam int COORD_W    = 16;
    localparam int LINK_W     = 14;
    localparam int SPD_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SHOULDER_W = 16;
    localparam int ELBOW_W    = 15;
    localparam int SQ_W       = 32;   // x^2 + y^2
    localparam int D_W        = 30;   // d^2 inside reach
    localparam int LSQ_W      = 28;   // link length squared
    localparam int REACH_W    = 30;   // (r1 + r2)^2
    localparam int LAW_W      = 32;   // law of cosines numerators
    localparam int REM_W      = 62;
    localparam int ROOT_W     = 31;
    localparam int TRIAL_W    = 64;
    localparam int MAG_W      = 30;
    localparam int NORM_STEPS = 5;
    localparam int CX_W       = 33;
    localparam int Z_W        = 28;
    localparam int ANG_W      = 30;
    localparam int PROD_W     = ANG_W + SPD_W + 1;
    localparam int STEP_SHIFT = 28;

    localparam logic [LINK_W-1:0] FIRST_LINK_RST  = 14'd4736;
    localparam logic [LINK_W-1:0] SECOND_LINK_RST = 14'd5131;
    localparam logic [SPD_W-1:0]  SPD_RST         = 16'd23029;

    // atan(2^-i) in Q.20 degrees
    localparam logic signed [Z_W-1:0] ATAN_Q20 [ATAN_LEN] = '{
        28'sd47185920, 28'sd27855475, 28'sd14718068, 28'sd7471121,
        28'sd3750058,  28'sd1876857,  28'sd938658,   28'sd469357,
        28'sd234682,   28'sd117342,   28'sd58671,    28'sd29335,
        28'sd14668,    28'sd7334,     28'sd3667,     28'sd1833,
        28'sd917,      28'sd458,      28'sd229,      28'sd115,
        28'sd57,       28'sd29,       28'sd14,       28'sd7
    };
    localparam logic signed [ANG_W-1:0] ANGLE_180 = 30'sd188743680;

    typedef enum logic [1:0] {
        ST_SOLVED       = 2'd0,
        ST_OUT_OF_REACH = 2'd1,
        ST_AT_ORIGIN    = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_LINK    = 2'd0,
        REG_SECOND_LINK   = 2'd1,
        REG_STEPS_PER_DEG = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [LSQ_W-1:0]   r1s;
        logic [LSQ_W-1:0]   r2s;
        logic [REACH_W-1:0] sum2;
        logic [LSQ_W-1:0]   diff2;
        logic [REM_W-1:0]   den2;
    } t_link_terms;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt_lane;

    typedef struct packed {
        t_sqrt_lane [1:0]           lane;
        t_status                    status;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [LAW_W-1:0]    m;
        logic signed [LAW_W-1:0]    n;
    } t_sqrt_item;

    typedef struct packed {
        logic [MAG_W-1:0] ux;
        logic [MAG_W-1:0] uy;
        logic             neg_x;
        logic             neg_y;
        logic             zero;
    } t_norm_lane;

    typedef struct packed {
        t_norm_lane [2:0] lane;
        t_status          status;
    } t_norm_item;

    typedef struct packed {
        logic signed [CX_W-1:0] cx;
        logic signed [CX_W-1:0] cy;
        logic signed [Z_W-1:0]  z;
        logic                   neg_x;
        logic                   neg_y;
        logic                   zero;
    } t_rot_lane;

    typedef struct packed {
        t_rot_lane [2:0] lane;
        t_status         status;
    } t_rot_item;

    typedef struct packed {
        logic signed [SHOULDER_W-1:0] shoulder;
        logic [ELBOW_W-1:0]           elbow;
        t_status                      status;
    } t_result;

    // magnitudes and signs of a vector, coarse scaled below 2^30
    function automatic t_norm_lane prep_lane(input logic signed [LAW_W-1:0] px,
                                             input logic signed [LAW_W-1:0] py);
        logic [LAW_W-1:0] ax;
        logic [LAW_W-1:0] ay;
        logic [LAW_W-1:0] mx;
        t_norm_lane       l;
        ax = px[LAW_W-1] ? $unsigned(-px) : $unsigned(px);
        ay = py[LAW_W-1] ? $unsigned(-py) : $unsigned(py);
        mx = (ax > ay) ? ax : ay;
        if (mx[LAW_W-1]) begin
            l.ux = MAG_W'(ax >> 2);
            l.uy = MAG_W'(ay >> 2);
        end else if (mx[LAW_W-2]) begin
            l.ux = MAG_W'(ax >> 1);
            l.uy = MAG_W'(ay >> 1);
        end else begin
            l.ux = MAG_W'(ax);
            l.uy = MAG_W'(ay);
        end
        l.neg_x = px[LAW_W-1];
        l.neg_y = py[LAW_W-1];
        l.zero  = (mx == '0);
        return l;
    endfunction

    function automatic t_rot_lane to_rot(input t_norm_lane l);
        t_rot_lane r;
        r.cx    = $signed({{(CX_W-MAG_W){1'b0}}, l.ux});
        r.cy    = $signed({{(CX_W-MAG_W){1'b0}}, l.uy});
        r.z     = '0;
        r.neg_x = l.neg_x;
        r.neg_y = l.neg_y;
        r.zero  = l.zero;
        return r;
    endfunction

    // first-quadrant angle back to the full circle
    function automatic logic signed [ANG_W-1:0] restore(input t_rot_lane l);
        logic signed [ANG_W-1:0] t;
        t = ANG_W'(l.z);
        if (l.neg_x) begin
            t = ANGLE_180 - t;
        end
        if (l.neg_y) begin
            t = -t;
        end
        if (l.zero) begin
            t = '0;
        end
        return t;
    endfunction

endpackage

>>> src/sik_if.sv
// handshake channels of the arm solver: target points in, joint positions out
// depends on sik_pkg
interface sik_target_if import sik_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;

    modport source(output valid, output target_x, output target_y, input ready);
    modport sink(input valid, input target_x, input target_y, output ready);
endinterface

interface sik_joint_if import sik_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [SHOULDER_W-1:0] shoulder_steps;
    logic [ELBOW_W-1:0]           elbow_steps;
    t_status                      solve_status;

    modport source(output valid, output shoulder_steps, output elbow_steps,
                   output solve_status, input ready);
    modport sink(input valid, input shoulder_steps, input elbow_steps,
                 input solve_status, output ready);
endinterface

>>> src/sik_front.sv
// front stages: squares, reach test, law of cosines terms and root operands
// depends on sik_pkg
module sik_front import sik_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_y,
    input  t_link_terms               i_link,
    output logic                      o_valid,
    output t_sqrt_item                o_item
);

    logic [4:0] r_valid;

    logic signed [COORD_W-1:0] r1_x, r1_y, r2_x, r2_y, r3_x, r3_y, r4_x, r4_y;
    logic [SQ_W-1:0]           r1_xx, r1_yy, r2_d2;
    logic signed [SQ_W-1:0]    n1_xe, n1_ye;
    logic [D_W-1:0]            r3_d;
    logic signed [LAW_W-1:0]   r3_m, r3_n, r4_m, r4_n;
    logic signed [LAW_W+1:0]   n3_m, n3_n;
    t_status                   n3_status, r3_status, r4_status;
    logic [LAW_W-1:0]          n4_am, n4_an;
    logic [TRIAL_W-1:0]        r4_msq, r4_nsq;
    logic [REM_W-1:0]          r4_den1, n4_prod;
    t_sqrt_item                n5_item, r5_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    assign n1_xe = SQ_W'(i_x);
    assign n1_ye = SQ_W'(i_y);

    always_comb begin
        n3_m = $signed({2'b00, r2_d2}) + $signed((LAW_W+2)'(i_link.r1s))
             - $signed((LAW_W+2)'(i_link.r2s));
        n3_n = $signed({2'b00, r2_d2}) - $signed((LAW_W+2)'(i_link.r1s))
             - $signed((LAW_W+2)'(i_link.r2s));
        if (r2_d2 == '0) begin
            n3_status = ST_AT_ORIGIN;
        end else if ((r2_d2 > i_link.sum2) || (r2_d2 < i_link.diff2)) begin
            n3_status = ST_OUT_OF_REACH;
        end else begin
            n3_status = ST_SOLVED;
        end
    end

    always_comb begin
        n4_am   = r3_m[LAW_W-1] ? $unsigned(-r3_m) : $unsigned(r3_m);
        n4_an   = r3_n[LAW_W-1] ? $unsigned(-r3_n) : $unsigned(r3_n);
        n4_prod = REM_W'(i_link.r1s) * REM_W'(r3_d);
    end

    always_comb begin
        n5_item = r5_item;
        n5_item.lane[0].rem  = ({{(TRIAL_W-REM_W){1'b0}}, r4_den1} >= r4_msq)
                             ? r4_den1 - REM_W'(r4_msq) : '0;
        n5_item.lane[0].root = '0;
        n5_item.lane[1].rem  = ({{(TRIAL_W-REM_W){1'b0}}, i_link.den2} >= r4_nsq)
                             ? i_link.den2 - REM_W'(r4_nsq) : '0;
        n5_item.lane[1].root = '0;
        n5_item.status = r4_status;
        n5_item.x      = r4_x;
        n5_item.y      = r4_y;
        n5_item.m      = r4_m;
        n5_item.n      = r4_n;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x      <= i_x;
            r1_y      <= i_y;
            r1_xx     <= $unsigned(n1_xe * n1_xe);
            r1_yy     <= $unsigned(n1_ye * n1_ye);
            r2_x      <= r1_x;
            r2_y      <= r1_y;
            r2_d2     <= r1_xx + r1_yy;
            r3_x      <= r2_x;
            r3_y      <= r2_y;
            r3_d      <= D_W'(r2_d2);
            r3_m      <= LAW_W'(n3_m);
            r3_n      <= LAW_W'(n3_n);
            r3_status <= n3_status;
            r4_x      <= r3_x;
            r4_y      <= r3_y;
            r4_m      <= r3_m;
            r4_n      <= r3_n;
            r4_status <= r3_status;
            r4_msq    <= TRIAL_W'(n4_am) * TRIAL_W'(n4_am);
            r4_nsq    <= TRIAL_W'(n4_an) * TRIAL_W'(n4_an);
            r4_den1   <= n4_prod << 2;
            r5_item   <= n5_item;
        end
    end

    assign o_valid = r_valid[4];
    assign o_item  = r5_item;

endmodule

>>> src/sik_sqrt_cell.sv
// one root bit of two integer square roots, with the item riding along
// depends on sik_pkg
module sik_sqrt_cell import sik_pkg::*; #(
    parameter int K = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_sqrt_item i_item,
    output logic       o_valid,
    output t_sqrt_item o_item
);

    logic       r_valid;
    t_sqrt_item r_item, n_item;

    always_comb begin
        logic [TRIAL_W-1:0] trial;
        n_item = i_item;
        for (int l = 0; l < 2; l++) begin
            // (2q + 2^k) * 2^k, bits of q and the new bit do not overlap
            trial = (TRIAL_W'(i_item.lane[l].root) << (K + 1))
                  | (TRIAL_W'(1) << (2 * K));
            if ({{(TRIAL_W-REM_W){1'b0}}, i_item.lane[l].rem} >= trial) begin
                n_item.lane[l].rem  = i_item.lane[l].rem - REM_W'(trial);
                n_item.lane[l].root = i_item.lane[l].root | (ROOT_W'(1) << K);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> src/sik_norm_cell.sv
// one step of the leading-bit normalization on three vectors
// depends on sik_pkg
module sik_norm_cell import sik_pkg::*; #(
    parameter int SHIFT = 1
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_norm_item i_item,
    output logic       o_valid,
    output t_norm_item o_item
);

    logic       r_valid;
    t_norm_item r_item, n_item;

    always_comb begin
        logic [MAG_W-1:0] mx;
        n_item = i_item;
        for (int l = 0; l < 3; l++) begin
            mx = (i_item.lane[l].ux > i_item.lane[l].uy) ? i_item.lane[l].ux
                                                         : i_item.lane[l].uy;
            // shift while the larger side stays below 2^30
            if (mx[MAG_W-1 -: SHIFT] == '0) begin
                n_item.lane[l].ux = i_item.lane[l].ux << SHIFT;
                n_item.lane[l].uy = i_item.lane[l].uy << SHIFT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> src/sik_cordic_cell.sv
// one vectoring micro-rotation on three vectors
// depends on sik_pkg
module sik_cordic_cell import sik_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_rot_item i_item,
    output logic      o_valid,
    output t_rot_item o_item
);

    logic      r_valid;
    t_rot_item r_item, n_item;

    always_comb begin
        logic signed [CX_W-1:0] dx;
        logic signed [CX_W-1:0] dy;
        n_item = i_item;
        for (int l = 0; l < 3; l++) begin
            dx = i_item.lane[l].cy >>> STEP;
            dy = i_item.lane[l].cx >>> STEP;
            if (!i_item.lane[l].cy[CX_W-1] && (i_item.lane[l].cy != '0)) begin
                n_item.lane[l].cx = i_item.lane[l].cx + dx;
                n_item.lane[l].cy = i_item.lane[l].cy - dy;
                n_item.lane[l].z  = i_item.lane[l].z + ATAN_Q20[STEP];
            end else begin
                n_item.lane[l].cx = i_item.lane[l].cx - dx;
                n_item.lane[l].cy = i_item.lane[l].cy + dy;
                n_item.lane[l].z  = i_item.lane[l].z - ATAN_Q20[STEP];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> src/scara_inverse_kinematics.sv
// top level of the two-link arm solver: config registers, cell chains, scaling
// depends on sik_pkg, sik_if, sik_front, sik_sqrt_cell, sik_norm_cell,
// sik_cordic_cell and scara_inverse_kinematics_assert.svh
//
// usage
// - i_target takes one target point (x, y, signed Q7.8 cm) per item with
//   valid/ready; o_joint returns one item per target: shoulder and elbow
//   positions in 1/64 motor steps plus a status (solved, out of reach, origin)
// - the config port writes link lengths and steps per degree by index; write
//   it only while no item is in flight
// - pipeline from accept to o_joint.valid: 5 front stages, 31 root cells,
//   1 prep stage, 5 normalize cells, the rotation cells, 2 scaling stages and
//   the output register
// - throughput is one item per cycle while the skid register is free; every stage
//   up to the scaling stages is a register that moves on a shared enable
// - when the receiver stalls, the output register holds its item and the
//   one item that arrives behind it lands in a skid register; ready then
//   drops and the whole chain freezes until the output drains
// - reset clears all valid bits and loads the default link lengths
//   (18.5 cm, about 20.04 cm) and steps per degree

`include "scara_inverse_kinematics_assert.svh"

module scara_inverse_kinematics import sik_pkg::*; #(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sik_target_if.sink           i_target,
    sik_joint_if.source          o_joint,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // configuration registers
    logic [LINK_W-1:0] r_r1, r_r2;
    logic [SPD_W-1:0]  r_spd;
    t_link_terms       r_link, n_link;

    // pipeline enable: the chain only moves while the skid register is free
    logic en;

    logic       front_v;
    t_sqrt_item front_item;

    logic [ROOT_W:0] sq_v;
    t_sqrt_item      sq_item [ROOT_W+1];

    logic       r_prep_v;
    t_norm_item r_prep_item, n_prep_item;

    logic [NORM_STEPS:0] nm_v;
    t_norm_item          nm_item [NORM_STEPS+1];

    logic [CORDIC_ITERATIONS:0] rot_v;
    t_rot_item                  rot_item [CORDIC_ITERATIONS+1];

    logic                    r_f1_v;
    logic signed [ANG_W-1:0] r_sh, r_el, n_sh, n_el;
    t_status                 r_f1_status;

    logic                     r_f2_v;
    logic signed [PROD_W-1:0] r_p_sh, r_p_el;
    t_status                  r_f2_status;

    logic signed [PROD_W-1:0] s_sh, s_el;
    t_result                  n_res;
    logic                     arriving;

    logic    r_out_v, r_skid_v;
    t_result r_out, r_skid;

    // config writes, masked to register width, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1  <= FIRST_LINK_RST;
            r_r2  <= SECOND_LINK_RST;
            r_spd <= SPD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FIRST_LINK:    r_r1  <= i_cfg_data[LINK_W-1:0];
                REG_SECOND_LINK:   r_r2  <= i_cfg_data[LINK_W-1:0];
                REG_STEPS_PER_DEG: r_spd <= i_cfg_data[SPD_W-1:0];
                default: ;
            endcase
        end
    end

    // link terms, registered from the config registers
    always_comb begin
        logic [LINK_W:0]   sum;
        logic [LINK_W-1:0] diff;
        sum  = (LINK_W+1)'(r_r1) + (LINK_W+1)'(r_r2);
        diff = (r_r1 > r_r2) ? r_r1 - r_r2 : r_r2 - r_r1;
        n_link.r1s   = LSQ_W'(r_r1) * LSQ_W'(r_r1);
        n_link.r2s   = LSQ_W'(r_r2) * LSQ_W'(r_r2);
        n_link.sum2  = REACH_W'(sum) * REACH_W'(sum);
        n_link.diff2 = LSQ_W'(diff) * LSQ_W'(diff);
        // 4 * r1^2 * r2^2 from the registered squares
        n_link.den2  = (REM_W'(r_link.r1s) * REM_W'(r_link.r2s)) << 2;
    end

    always_ff @(posedge i_clk) begin
        r_link <= n_link;
    end

    assign en = !r_skid_v;
    assign i_target.ready = en;

    sik_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_target.valid),
        .i_x     (i_target.target_x),
        .i_y     (i_target.target_y),
        .i_link  (r_link),
        .o_valid (front_v),
        .o_item  (front_item)
    );

    // square roots of both law of cosines remainders, msb first
    assign sq_v[0]    = front_v;
    assign sq_item[0] = front_item;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        sik_sqrt_cell #(
            .K (ROOT_W - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[g]),
            .i_item  (sq_item[g]),
            .o_valid (sq_v[g+1]),
            .o_item  (sq_item[g+1])
        );
    end

    // three vectors: target itself, shoulder offset (m, root), elbow (n, root)
    always_comb begin
        n_prep_item.lane[0] = prep_lane(LAW_W'(sq_item[ROOT_W].x),
                                        LAW_W'(sq_item[ROOT_W].y));
        n_prep_item.lane[1] = prep_lane(sq_item[ROOT_W].m,
                                        $signed({1'b0, sq_item[ROOT_W].lane[0].root}));
        n_prep_item.lane[2] = prep_lane(sq_item[ROOT_W].n,
                                        $signed({1'b0, sq_item[ROOT_W].lane[1].root}));
        n_prep_item.status  = sq_item[ROOT_W].status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_v <= 1'b0;
        end else if (en) begin
            r_prep_v <= sq_v[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prep_item <= n_prep_item;
        end
    end

    // bring the larger magnitude up to bit 29, shifts of 16, 8, 4, 2, 1
    assign nm_v[0]    = r_prep_v;
    assign nm_item[0] = r_prep_item;

    for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
        sik_norm_cell #(
            .SHIFT (1 << (NORM_STEPS - 1 - g))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (nm_v[g]),
            .i_item  (nm_item[g]),
            .o_valid (nm_v[g+1]),
            .o_item  (nm_item[g+1])
        );
    end

    // rotation chain, one cell per CORDIC iteration, each with its atan table entry
    assign rot_v[0] = nm_v[NORM_STEPS];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            rot_item[0].lane[l] = to_rot(nm_item[NORM_STEPS].lane[l]);
        end
        rot_item[0].status = nm_item[NORM_STEPS].status;
    end

    for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cordic
        sik_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (rot_v[g]),
            .i_item  (rot_item[g]),
            .o_valid (rot_v[g+1]),
            .o_item  (rot_item[g+1])
        );
    end

    // joint angles: shoulder = base angle minus offset, elbow straight through
    always_comb begin
        n_sh = restore(rot_item[CORDIC_ITERATIONS].lane[0])
             - restore(rot_item[CORDIC_ITERATIONS].lane[1]);
        n_el = restore(rot_item[CORDIC_ITERATIONS].lane[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else if (en) begin
            r_f1_v <= rot_v[CORDIC_ITERATIONS];
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sh        <= n_sh;
            r_el        <= n_el;
            r_f1_status <= rot_item[CORDIC_ITERATIONS].status;
            r_p_sh      <= PROD_W'(r_sh) * PROD_W'($signed({1'b0, r_spd}));
            r_p_el      <= PROD_W'(r_el) * PROD_W'($signed({1'b0, r_spd}));
            r_f2_status <= r_f1_status;
        end
    end

    // round half up to 1/64 steps, then clamp to the field ranges; unsolved items get zero
    always_comb begin
        s_sh = (r_p_sh + (PROD_W'(1) <<< (STEP_SHIFT - 1))) >>> STEP_SHIFT;
        s_el = (r_p_el + (PROD_W'(1) <<< (STEP_SHIFT - 1))) >>> STEP_SHIFT;

        if (s_sh[PROD_W-1]) begin
            n_res.shoulder = (&s_sh[PROD_W-2:SHOULDER_W-1]) ? SHOULDER_W'(s_sh)
                           : {1'b1, {(SHOULDER_W-1){1'b0}}};
        end else begin
            n_res.shoulder = (~|s_sh[PROD_W-2:SHOULDER_W-1]) ? SHOULDER_W'(s_sh)
                           : {1'b0, {(SHOULDER_W-1){1'b1}}};
        end

        if (s_el[PROD_W-1]) begin
            n_res.elbow = '0;
        end else begin
            n_res.elbow = (~|s_el[PROD_W-2:ELBOW_W]) ? ELBOW_W'(s_el) : '1;
        end

        n_res.status = r_f2_status;
        if (r_f2_status != ST_SOLVED) begin
            n_res.shoulder = '0;
            n_res.elbow    = '0;
        end
    end

    assign arriving = r_f2_v && en;

    // output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_joint.ready) begin
            r_out_v  <= r_skid_v || arriving;
            r_skid_v <= 1'b0;
        end else if (arriving) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_joint.ready) begin
            r_out <= r_skid_v ? r_skid : n_res;
        end
        if (r_out_v && !o_joint.ready && arriving) begin
            r_skid <= n_res;
        end
    end

    assign o_joint.valid          = r_out_v;
    assign o_joint.shoulder_steps = r_out.shoulder;
    assign o_joint.elbow_steps    = r_out.elbow;
    assign o_joint.solve_status   = r_out.status;

    // a parked item always sits behind a shown one
    `SIK_ASSERT_IMPLY(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    // an item arriving at a stalled output must be parked, not dropped
    `SIK_ASSERT_NEXT(a_stall_parks_item, i_clk, i_rst_n, r_out_v && !o_joint.ready && arriving, r_skid_v)
    // unsolved targets carry zero positions
    `SIK_ASSERT_IMPLY(a_fault_zero_steps, i_clk, i_rst_n, o_joint.valid && (o_joint.solve_status != ST_SOLVED), (o_joint.shoulder_steps == '0) && (o_joint.elbow_steps == '0))

endmodule

>>> bench/tb.sv
// self-checking bench for the two-link arm solver: directed table, then random targets
// depends on sik_pkg, sik_if and the scara_inverse_kinematics top level
module tb;
    import sik_pkg::*;

    localparam int ROTATIONS = 16;
    localparam int LATENCY   = 45 + ROTATIONS;
    localparam int CYCLE_CAP = 400000;
    localparam int N_RANDOM  = 830;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    always #1 i_clk = ~i_clk;

    sik_target_if target_ch ();
    sik_joint_if joint_ch ();

    scara_inverse_kinematics #(.CORDIC_ITERATIONS(ROTATIONS)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_target(target_ch.sink),
        .o_joint(joint_ch.source), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // shadow of the config registers
    longint link1, link2, spd;

    t_result joint_queue[$];
    int errors = 0;
    int cycles = 0;
    int send_idle = 0;
    int recv_stall = 0;

    // directed stimulus rows; want_fixed marks rows whose result is typed in
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit want_fixed;
        t_result want;
    } t_row;

    function automatic longint shr_floor(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint int_root(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // cordic atan2 in Q.20 degrees
    function automatic longint heading_q20(longint px, longint py);
        longint unsigned ux, uy, mag;
        longint cx, cy, z, dx, dy;
        ux = px < 0 ? -px : px;
        uy = py < 0 ? -py : py;
        mag = ux > uy ? ux : uy;
        z = 0;
        if (mag == 0) return 0;
        while (mag >= (64'd1 << 30)) begin
            mag >>= 1; ux >>= 1; uy >>= 1;
        end
        while (mag < (64'd1 << 29)) begin
            mag <<= 1; ux <<= 1; uy <<= 1;
        end
        cx = ux;
        cy = uy;
        for (int i = 0; i < ROTATIONS && i < ATAN_LEN; i++) begin
            dx = shr_floor(cy, i);
            dy = shr_floor(cx, i);
            if (cy > 0) begin
                cx += dx; cy -= dy; z += ATAN_Q20[i];
            end else begin
                cx -= dx; cy += dy; z -= ATAN_Q20[i];
            end
        end
        if (px < 0) z = 180 * (64'sd1 << 20) - z;
        if (py < 0) z = -z;
        return z;
    endfunction

    // acos(c / den) as atan2(sqrt(den^2 - c^2), c)
    function automatic longint cosine_angle(longint c, longint unsigned den_sq);
        longint unsigned c_sq, rem;
        c_sq = c < 0 ? -c : c;
        c_sq = c_sq * c_sq;
        rem = den_sq >= c_sq ? den_sq - c_sq : 0;
        return heading_q20(c, int_root(rem));
    endfunction

    function automatic longint angle_to_steps(longint deg, longint lo, longint hi);
        longint s;
        s = shr_floor(deg * spd + (64'sd1 << 27), STEP_SHIFT);
        if (s < lo) s = lo;
        if (s > hi) s = hi;
        return s;
    endfunction

    function automatic t_result solve_joints(longint x, longint y);
        t_result r;
        longint d2, r1s, r2s, m, n, sh, el;
        d2 = x * x + y * y;
        r1s = link1 * link1;
        r2s = link2 * link2;
        r.shoulder = '0;
        r.elbow = '0;
        r.status = ST_SOLVED;
        if (d2 == 0) begin
            r.status = ST_AT_ORIGIN;
        end else if (d2 > (link1 + link2) * (link1 + link2)
                     || d2 < (link1 - link2) * (link1 - link2)) begin
            r.status = ST_OUT_OF_REACH;
        end else begin
            m = d2 + r1s - r2s;
            n = d2 - r1s - r2s;
            sh = heading_q20(x, y) - cosine_angle(m, 4 * r1s * d2);
            el = cosine_angle(n, 4 * r1s * r2s);
            r.shoulder = 16'(angle_to_steps(sh, -32768, 32767));
            r.elbow = 15'(angle_to_steps(el, 0, 32767));
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d want %0d", what, got, want);
    endtask

    // receiver with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            joint_ch.ready <= 1'b0;
        end else begin
            if (joint_ch.valid && joint_ch.ready) begin
                if (joint_queue.size() == 0) begin
                    report_mismatch("unexpected item", 0, 0);
                end else begin
                    t_result w;
                    w = joint_queue.pop_front();
                    if (joint_ch.shoulder_steps !== w.shoulder)
                        report_mismatch("shoulder", joint_ch.shoulder_steps, w.shoulder);
                    if (joint_ch.elbow_steps !== w.elbow)
                        report_mismatch("elbow", joint_ch.elbow_steps, w.elbow);
                    if (joint_ch.solve_status !== w.status)
                        report_mismatch("status", joint_ch.solve_status, w.status);
                end
            end
            joint_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // one item per call; holds valid until accepted, idles at random before
    task automatic send_target(logic signed [15:0] x, logic signed [15:0] y,
                               bit fixed, t_result want);
        while ($urandom_range(99) < send_idle) begin
            target_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        target_ch.valid <= 1'b1;
        target_ch.target_x <= x;
        target_ch.target_y <= y;
        @(posedge i_clk);
        while (!target_ch.ready) @(posedge i_clk);
        joint_queue.push_back(fixed ? want : solve_joints(x, y));
    endtask

    task automatic drain;
        target_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (joint_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, longint value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 16'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_FIRST_LINK:    link1 = value & 16'h3FFF;
            REG_SECOND_LINK:   link2 = value & 16'h3FFF;
            REG_STEPS_PER_DEG: spd = value & 16'hFFFF;
            default: ;
        endcase
    endtask

    // mostly reachable targets inside the annulus, some anywhere
    task automatic random_target(output logic signed [15:0] x, output logic signed [15:0] y);
        longint rad, ang, lo, hi;
        if ($urandom_range(99) < 25) begin
            x = 16'($urandom);
            y = 16'($urandom);
        end else begin
            lo = link1 > link2 ? link1 - link2 : link2 - link1;
            hi = link1 + link2;
            if (hi > 32767) hi = 32767;
            rad = $urandom_range(hi, lo);
            ang = $urandom_range(359);
            x = 16'($rtoi(rad * $cos(ang * 3.14159265 / 180.0)));
            y = 16'($rtoi(rad * $sin(ang * 3.14159265 / 180.0)));
        end
    endtask

    t_row rows[$];
    t_result dont_care;
    logic signed [15:0] rx, ry;

    initial begin
        target_ch.valid = 1'b0;
        target_ch.target_x = '0;
        target_ch.target_y = '0;
        joint_ch.ready = 1'b0;
        link1 = FIRST_LINK_RST;
        link2 = SECOND_LINK_RST;
        spd = SPD_RST;
        dont_care = '0;
        // directed: origin, out of reach both ways, extremes, near-full reach
        rows.push_back('{16'sd0, 16'sd0, 1'b1, '{16'sd0, 15'd0, ST_AT_ORIGIN}});
        rows.push_back('{16'sd32767, 16'sd32767, 1'b1, '{16'sd0, 15'd0, ST_OUT_OF_REACH}});
        rows.push_back('{-16'sd32768, -16'sd32768, 1'b1, '{16'sd0, 15'd0, ST_OUT_OF_REACH}});
        rows.push_back('{-16'sd32768, 16'sd0, 1'b1, '{16'sd0, 15'd0, ST_OUT_OF_REACH}});
        rows.push_back('{16'sd100, 16'sd0, 1'b1, '{16'sd0, 15'd0, ST_OUT_OF_REACH}});
        rows.push_back('{16'sd0, -16'sd1, 1'b1, '{16'sd0, 15'd0, ST_OUT_OF_REACH}});
        rows.push_back('{16'sd9867, 16'sd0, 1'b0, dont_care});
        rows.push_back('{16'sd0, 16'sd9867, 1'b0, dont_care});
        rows.push_back('{-16'sd9867, 16'sd0, 1'b0, dont_care});
        rows.push_back('{16'sd0, -16'sd9867, 1'b0, dont_care});
        rows.push_back('{16'sd5000, 16'sd5000, 1'b0, dont_care});
        rows.push_back('{-16'sd5000, 16'sd5000, 1'b0, dont_care});
        rows.push_back('{-16'sd5000, -16'sd5000, 1'b0, dont_care});
        rows.push_back('{16'sd5000, -16'sd5000, 1'b0, dont_care});
        rows.push_back('{16'sd396, 16'sd0, 1'b0, dont_care});
        rows.push_back('{16'sd1000, -16'sd200, 1'b0, dont_care});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_target(rows[i].x, rows[i].y, rows[i].want_fixed, rows[i].want);
        // sender waits for every result before going on
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 61; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 61; end
                default: begin send_idle = 13; recv_stall = 13; end
            endcase
            // register settings per phase, extremes included
            case (phase)
                0: ;
                1: begin write_reg(REG_FIRST_LINK, 1); write_reg(REG_SECOND_LINK, 16383);
                         write_reg(REG_STEPS_PER_DEG, 65535); end
                2: begin write_reg(REG_FIRST_LINK, 16383); write_reg(REG_SECOND_LINK, 1);
                         write_reg(REG_STEPS_PER_DEG, 1); end
                3: begin write_reg(REG_FIRST_LINK, 16383); write_reg(REG_SECOND_LINK, 16383);
                         write_reg(REG_STEPS_PER_DEG, 16384); end
                4: begin write_reg(REG_FIRST_LINK, $urandom_range(16383, 1));
                         write_reg(REG_SECOND_LINK, $urandom_range(16383, 1));
                         write_reg(REG_STEPS_PER_DEG, $urandom_range(65535, 1)); end
                5: begin write_reg(REG_FIRST_LINK, 2000); write_reg(REG_SECOND_LINK, 2000);
                         write_reg(REG_STEPS_PER_DEG, 40000); end
                6: begin write_reg(REG_FIRST_LINK, 8000); write_reg(REG_SECOND_LINK, 3000);
                         write_reg(REG_STEPS_PER_DEG, 30000); end
                default: begin write_reg(REG_FIRST_LINK, FIRST_LINK_RST);
                         write_reg(REG_SECOND_LINK, SECOND_LINK_RST);
                         write_reg(REG_STEPS_PER_DEG, SPD_RST); end
            endcase
            for (int k = 0; k < N_RANDOM / 8; k++) begin
                random_target(rx, ry);
                send_target(rx, ry, 1'b0, dont_care);
            end
            drain();
        end

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
